/* design/imu_tilt_complementary_filter_assert.svh */
// Assertion macros for the tilt filter
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define ITCF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITCF_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define ITCF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ITCF_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

/* design/itcf_pkg.sv */
// ----------------------------------------------------------------------------
// itcf_pkg
// Types and constants shared by the tilt filter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package itcf_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } itcf_in_t;

  typedef struct packed {
    logic signed [19:0] tilt_x;
    logic signed [19:0] tilt_y;
  } itcf_out_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic               zero_mag;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } itcf_job_t;

  localparam logic [1:0] CFG_ACCEL_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_GYRO_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_GYRO_GAIN    = 2'd2;

  localparam logic signed [31:0] ANGLE_LIMIT = 32'sd5898240;
  localparam int MAX_STEPS = 24;

  function automatic logic [22:0] atan_q16(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0: v = 23'd2949120;  5'd1: v = 23'd1740967;  5'd2: v = 23'd919879;
      5'd3: v = 23'd466945;   5'd4: v = 23'd234379;   5'd5: v = 23'd117304;
      5'd6: v = 23'd58666;    5'd7: v = 23'd29335;    5'd8: v = 23'd14668;
      5'd9: v = 23'd7334;     5'd10: v = 23'd3667;    5'd11: v = 23'd1833;
      5'd12: v = 23'd917;     5'd13: v = 23'd458;     5'd14: v = 23'd229;
      5'd15: v = 23'd115;     5'd16: v = 23'd57;      5'd17: v = 23'd29;
      5'd18: v = 23'd14;      5'd19: v = 23'd7;       5'd20: v = 23'd4;
      5'd21: v = 23'd2;       5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/itcf_front.sv */
// ----------------------------------------------------------------------------
// itcf_front
// Accepts samples, flags zero magnitude and queues jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module itcf_front
  import itcf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire itcf_in_t  in_data,
  output logic           job_valid,
  input  wire logic      job_ready,
  output itcf_job_t      job_data
);
  // two-entry queue
  itcf_job_t   q_r [2];
  logic        wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  itcf_job_t   job;
  logic        push, pop;

  always_comb begin
    job.zero_mag = (in_data.accel_x == 16'sd0) && (in_data.accel_y == 16'sd0)
                   && (in_data.accel_z == 16'sd0);
    job.accel_x = in_data.accel_x;
    job.accel_y = in_data.accel_y;
    job.accel_z = in_data.accel_z;
    job.gyro_x  = in_data.gyro_x;
    job.gyro_y  = in_data.gyro_y;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job_data  = q_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = job_valid && job_ready;

  // advance pointers and count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= job;
    end
  end

endmodule
`default_nettype wire

/* design/itcf_back.sv */
// ----------------------------------------------------------------------------
// itcf_back
// Square root, CORDIC, gyro integration and blend for one job at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "imu_tilt_complementary_filter_assert.svh"
module itcf_back
  import itcf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  wire itcf_job_t   job_data,
  input  wire logic [16:0] accel_weight,
  input  wire logic [16:0] gyro_weight,
  input  wire logic [15:0] gyro_gain,
  output logic             out_valid,
  input  wire logic        out_ready,
  output itcf_out_t        out_data
);
  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HSQ   = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_CORD  = 4'd3;
  localparam logic [3:0] S_NEXT  = 4'd4;
  localparam logic [3:0] S_GMUL  = 4'd5;
  localparam logic [3:0] S_GACC  = 4'd6;
  localparam logic [3:0] S_BMA   = 4'd7;
  localparam logic [3:0] S_BMG   = 4'd8;
  localparam logic [3:0] S_BSUM  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]  st_r, st_nxt;
  itcf_job_t   job_r;
  logic        axis_r;            // 0: X tilt, 1: Y tilt
  logic [4:0]  cnt_r;
  // square root (n up to 2^47)
  logic [47:0] rem_r;
  logic [47:0] root_r;
  logic [47:0] bit_r;
  // CORDIC
  logic signed [27:0] cx_r, cy_r;
  logic signed [24:0] cz_r;
  logic signed [24:0] ang_r [2];
  // gyro path
  logic signed [31:0] gax_r, gay_r;
  logic signed [32:0] gprod_r;
  logic signed [42:0] pa_r;
  logic signed [48:0] pg_r;
  logic signed [19:0] tx_r, ty_r;
  itcf_out_t          out_r;
  logic               ov_r;

  logic signed [15:0] a_s, b_s, c_s;
  logic [31:0]        hsum;
  logic signed [27:0] dx, dy;
  logic signed [24:0] at;
  logic signed [24:0] zc;
  logic signed [33:0] gsum;
  logic signed [31:0] gsat;
  logic signed [31:0] gsel;
  logic signed [49:0] bsum;
  logic signed [25:0] tsh;
  logic signed [19:0] tsat;
  logic [47:0]        trial;

  always_comb begin
    a_s = axis_r ? job_r.accel_y : job_r.accel_x;
    b_s = axis_r ? job_r.accel_x : job_r.accel_y;
    c_s = job_r.accel_z;
    hsum = 32'(b_s * b_s) + 32'(c_s * c_s);
    dx = cy_r >>> cnt_r;
    dy = cx_r >>> cnt_r;
    at = $signed({2'b00, atan_q16(cnt_r)});
    zc = (cz_r > 25'(ANGLE_LIMIT)) ? 25'(ANGLE_LIMIT)
       : (cz_r < -25'(ANGLE_LIMIT)) ? -25'(ANGLE_LIMIT) : cz_r;
    gsel = axis_r ? gay_r : gax_r;
    gsum = 34'(gsel) + 34'(gprod_r >>> 8);
    gsat = (gsum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF
         : (gsum < -34'sh80000000) ? -32'sh80000000 : gsum[31:0];
    bsum = 50'(pa_r) + 50'(pg_r) + 50'sd8388608;
    tsh  = bsum[49:24];
    tsat = (tsh > 26'sd524287) ? 20'sh7FFFF
         : (tsh < -26'sd524288) ? -20'sh80000 : tsh[19:0];
    trial = root_r + bit_r;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_HSQ;
      S_HSQ:  st_nxt = job_r.zero_mag ? S_NEXT : S_SQRT;
      S_SQRT: if (bit_r == 48'd0) st_nxt = S_CORD;
      S_CORD: if (cnt_r == 5'(NSTEP - 1)) st_nxt = S_NEXT;
      S_NEXT: st_nxt = axis_r ? S_GMUL : S_HSQ;
      S_GMUL: st_nxt = S_GACC;
      S_GACC: st_nxt = axis_r ? S_BMA : S_GMUL;
      S_BMA:  st_nxt = S_BMG;
      S_BMG:  st_nxt = S_BSUM;
      S_BSUM: st_nxt = axis_r ? S_DONE : S_BMA;
      S_DONE: if (!ov_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign job_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      gax_r <= '0;
      gay_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (st_r == S_GACC) begin
        if (axis_r) gay_r <= gsat;
        else        gax_r <= gsat;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        job_r  <= job_data;
        axis_r <= 1'b0;
      end
      S_HSQ: begin
        rem_r  <= {hsum, 16'd0};
        root_r <= '0;
        bit_r  <= 48'd1 << 46;
        cnt_r  <= '0;
        ang_r[axis_r] <= '0;
      end
      S_SQRT: begin
        if (bit_r != 48'd0) begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          cx_r <= $signed({4'd0, root_r[23:0]});
          cy_r <= 28'(a_s) <<< 8;
          cz_r <= '0;
        end
      end
      S_CORD: begin
        if (!cy_r[27]) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      S_NEXT: begin
        // take the clamped angle once the last rotation has landed
        if (!job_r.zero_mag) ang_r[axis_r] <= zc;
        axis_r <= ~axis_r;
      end
      S_GMUL: begin
        // gyro Y feeds X angle
        gprod_r <= 33'((axis_r ? job_r.gyro_x : job_r.gyro_y) * $signed({1'b0, gyro_gain}));
      end
      S_GACC: axis_r <= ~axis_r;
      S_BMA: pa_r <= 43'($signed({1'b0, accel_weight}) * ang_r[axis_r]);
      S_BMG: pg_r <= 49'($signed({1'b0, gyro_weight}) * gsel);
      S_BSUM: begin
        axis_r <= ~axis_r;
        if (!axis_r) tx_r <= tsat;
        else ty_r <= tsat;
      end
      S_DONE: begin
        // load the result only once the previous one has gone
        if (!ov_r || out_ready) out_r <= '{tilt_x: tx_r, tilt_y: ty_r};
      end
      default: ;
    endcase
  end

  `ITCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "valid dropped")
  `ITCF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data), "data moved")
  `ITCF_ASSERT_IMPL(a_ready_idle, clk, rst_n, job_ready |-> !(st_r == S_DONE), "ready outside idle")
  `ITCF_ASSERT_NEXT(a_take, clk, rst_n, job_valid && job_ready, st_r == S_HSQ, "job not started")
endmodule
`default_nettype wire

/* design/imu_tilt_complementary_filter.sv */
// The back end handles one sample at a time, running the square root and CORDIC loop
// per axis; a sample whose three accel values are all zero skips both.
// A two-entry queue buffers input, and a waiting result holds the back end in its
// final state.
// Reset (synchronous, rst_n low): weights and gain to defaults, gyro angles to 0.
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Complementary tilt filter: accelerometer asin via sqrt and CORDIC plus gyro.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_tilt_complementary_filter
  import itcf_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire itcf_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output itcf_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  logic [16:0] aw_r, gw_r;
  logic [15:0] gg_r;
  logic        jv, jr;
  itcf_job_t   jd;

  assign cfg_ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= 17'd62259;
      gw_r <= 17'd3277;
      gg_r <= 16'd1231;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACCEL_WEIGHT: aw_r <= cfg_data;
        CFG_GYRO_WEIGHT:  gw_r <= cfg_data;
        CFG_GYRO_GAIN:    gg_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  itcf_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(jv), .job_ready(jr), .job_data(jd)
  );

  itcf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job_valid(jv), .job_ready(jr), .job_data(jd),
    .accel_weight(aw_r), .gyro_weight(gw_r), .gyro_gain(gg_r),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

/* bench/tb_imu_tilt_complementary_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_tilt_complementary_filter
// Drives accelerometer and gyro samples into the tilt filter, predicts each
// blended tilt pair in fixed point and compares every output transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

class tilt_scoreboard;
  localparam int STEPS = 16;
  bit [16:0] accel_weight;
  bit [16:0] gyro_weight;
  bit [15:0] gyro_gain;
  logic signed [31:0] angle_x;
  logic signed [31:0] angle_y;
  itcf_pkg::itcf_out_t pending[$];
  int errors;

  function new();
    reset_state();
    errors = 0;
  endfunction

  function void reset_state();
    accel_weight = 17'd62259;
    gyro_weight  = 17'd3277;
    gyro_gain    = 16'd1231;
    angle_x = '0;
    angle_y = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [16:0] val);
    case (idx)
      itcf_pkg::CFG_ACCEL_WEIGHT: accel_weight = val;
      itcf_pkg::CFG_GYRO_WEIGHT:  gyro_weight = val;
      itcf_pkg::CFG_GYRO_GAIN:    gyro_gain = val[15:0];
      default: ;
    endcase
  endfunction

  static function longint isqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  static function longint arctan_q16(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // Vectoring CORDIC against the horizontal magnitude, Q16 degrees
  static function longint tilt_angle(longint a, longint b, longint c);
    longint x, y, z, dx, dy;
    x = isqrt((b * b + c * c) <<< 16);
    y = a * 256;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q16(i);
      end else begin
        x -= dx; y += dy; z -= arctan_q16(i);
      end
    end
    if (z > 5898240) z = 5898240;
    if (z < -5898240) z = -5898240;
    return z;
  endfunction

  function logic signed [31:0] integrate(logic signed [31:0] acc, longint rate);
    longint v;
    v = longint'(acc) + ((rate * longint'(gyro_gain)) >>> 8);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function logic signed [19:0] blend(longint acc_ang, logic signed [31:0] gang);
    longint s, t;
    s = longint'(accel_weight) * acc_ang + longint'(gyro_weight) * longint'(gang);
    t = (s + (64'sd1 <<< 23)) >>> 24;
    if (t > 524287) t = 524287;
    if (t < -524288) t = -524288;
    return t[19:0];
  endfunction

  // Note an accepted sample and queue its expected tilt pair
  function void note_sample(itcf_pkg::itcf_in_t s);
    longint ax, ay, az, ang_x, ang_y;
    itcf_pkg::itcf_out_t e;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    ang_x = 0; ang_y = 0;
    if (ax != 0 || ay != 0 || az != 0) begin
      ang_x = tilt_angle(ax, ay, az);
      ang_y = tilt_angle(ay, ax, az);
    end
    angle_x = integrate(angle_x, longint'(s.gyro_y));
    angle_y = integrate(angle_y, longint'(s.gyro_x));
    e.tilt_x = blend(ang_x, angle_x);
    e.tilt_y = blend(ang_y, angle_y);
    pending.push_back(e);
  endfunction

  function void check_result(itcf_pkg::itcf_out_t r);
    itcf_pkg::itcf_out_t e;
    if (pending.size() == 0) begin
      $error("unexpected output transfer: tilt_x %0d tilt_y %0d", r.tilt_x, r.tilt_y);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (r.tilt_x !== e.tilt_x) begin
      $error("tilt_x expected %0d actual %0d", e.tilt_x, r.tilt_x);
      errors++;
    end
    if (r.tilt_y !== e.tilt_y) begin
      $error("tilt_y expected %0d actual %0d", e.tilt_y, r.tilt_y);
      errors++;
    end
  endfunction
endclass

module tb_imu_tilt_complementary_filter;
  import itcf_pkg::*;

  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  itcf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  itcf_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int sender_idle = 0;
  int receiver_idle = 0;
  bit hold_off = 1'b0;
  int quiet = 0;
  tilt_scoreboard sb;

  imu_tilt_complementary_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off when asked
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_data);
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one sample; valid stays high into the next sample unless the sender idles
  task automatic send_sample(itcf_in_t s);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic itcf_in_t rand_sample();
    itcf_in_t s;
    s.accel_x = rand_field();
    s.accel_y = rand_field();
    s.accel_z = rand_field();
    s.gyro_x = rand_field();
    s.gyro_y = rand_field();
    if ($urandom_range(19) == 0) begin
      s.accel_x = '0; s.accel_y = '0; s.accel_z = '0;
    end
    return s;
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) send_sample(rand_sample());
  endtask

  initial begin
    itcf_in_t s;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero magnitude, vertical axes
    sender_idle = 9; receiver_idle = 46;
    send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100});
    send_sample('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_sample('{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0});
    send_sample('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    send_sample('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    send_sample('{16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1});
    send_sample('{16'sd8192, 16'sd8192, 16'sd11585, 16'sd0, 16'sd0});
    drain();

    // Extreme weights and gain; drive the gyro angles steadily in one direction
    write_cfg(CFG_ACCEL_WEIGHT, 17'd65536);
    write_cfg(CFG_GYRO_WEIGHT, 17'd65536);
    write_cfg(CFG_GYRO_GAIN, 17'd65535);
    write_cfg(2'd3, 17'h1ffff);
    for (int i = 0; i < 8; i++)
      send_sample('{16'sd16384, -16'sd16384, 16'sd0, -16'sd32768, 16'sd32767});
    random_burst(150);
    drain();

    // Swap idling, zero weights
    sender_idle = 46; receiver_idle = 9;
    write_cfg(CFG_ACCEL_WEIGHT, 17'd0);
    write_cfg(CFG_GYRO_WEIGHT, 17'd0);
    write_cfg(CFG_GYRO_GAIN, 17'd0);
    random_burst(100);
    drain();

    // Random settings
    write_cfg(CFG_ACCEL_WEIGHT, 17'($urandom));
    write_cfg(CFG_GYRO_WEIGHT, 17'($urandom));
    write_cfg(CFG_GYRO_GAIN, 17'($urandom));
    random_burst(120);
    drain();

    // No idling, defaults back, long receiver hold-off so the input stalls
    sender_idle = 0; receiver_idle = 0;
    write_cfg(CFG_ACCEL_WEIGHT, 17'd62259);
    write_cfg(CFG_GYRO_WEIGHT, 17'd3277);
    write_cfg(CFG_GYRO_GAIN, 17'd1231);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      random_burst(30);
    join
    drain();

    random_burst(300);
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
